// ----- rtl/bmhq_pkg.sv -----
// Package for the binary max-heap priority queue.
// Holds the fixed port widths, action codes and error codes.
// No dependencies; used by the top level, its checker and the testbench.
package bmhq_pkg;

	// Fixed widths of the external fields
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 11;
	localparam int ERR_W   = 2;

	typedef logic [ERR_W-1:0] err_t;

	// Action codes
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// Error codes
	localparam err_t ERR_OK    = 2'd0;
	localparam err_t ERR_FULL  = 2'd1;
	localparam err_t ERR_EMPTY = 2'd2;

endpackage

// ----- rtl/binary_max_heap_queue_top.sv -----
// Binary max-heap priority queue, top level.
// Holds the heap store memory, the sift sequencer and the result register.
// Depends on bmhq_pkg.

// Each transfer on the input channel is a push of a signed value or a pop of
// the largest entry; each gives exactly one result (largest value, count,
// empty flag, error code). The heap sits in one single-port-write,
// registered-read memory of CAPACITY words, so an item walks the tree one
// level at a time. A push reads the parent and then compares and writes at
// each level it climbs, and a pop reads the two children and then compares
// and writes at each level it descends. The longest item is a pop that sinks
// to the bottom level; a refused item goes straight to its result.
// One item is worked on at a time; the next input is taken as soon as the
// result is loaded into the output register, even if that result is still
// waiting to be taken. The memory needs no clearing after reset. A push when
// full or a pop when empty changes nothing and reports an error code.
module binary_max_heap_queue_top
	import bmhq_pkg::*;
#(
	parameter int CAPACITY   = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [VALUE_W-1:0] top_value,
	output logic [COUNT_W-1:0]        count,
	output logic                      is_empty,
	output logic [ERR_W-1:0]          error
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_POP_CAP,
		S_DN_CHK,
		S_DN_RD2,
		S_DN_CMP,
		S_DONE
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic out_valid_q;

	// Working registers of the current item
	logic [AW-1:0]                i_q;
	logic signed [DATA_WIDTH-1:0] v_q;
	logic signed [DATA_WIDTH-1:0] m1_q;
	err_t                         err_q;

	// Heap store and its ports
	logic signed [DATA_WIDTH-1:0] mem_q [CAPACITY];
	logic signed [DATA_WIDTH-1:0] rd_data_q;
	logic signed [DATA_WIDTH-1:0] top_q;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic signed [DATA_WIDTH-1:0] wr_data;

	// Result register payload
	logic signed [VALUE_W-1:0] top_out_q;
	logic [COUNT_W-1:0]        cnt_out_q;
	logic                      empty_out_q;
	err_t                      err_out_q;

	logic                         in_xfer;
	logic                         out_free;
	logic                         full;
	logic                         empty;
	logic signed [DATA_WIDTH-1:0] in_data;
	logic [AW-1:0]                parent;
	logic [XW-1:0]                c1;
	logic [XW-1:0]                c2;
	logic [XW-1:0]                cnt_x;
	logic                         take_c2;
	logic signed [DATA_WIDTH-1:0] best_val;
	logic [AW-1:0]                best_idx;
	logic                         up_move;
	logic                         dn_move;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign full     = (cnt_q == CW'(CAPACITY));
	assign empty    = (cnt_q == '0);

	// Low DATA_WIDTH bits of the raw input pattern
	assign in_data = DATA_WIDTH'(64'($unsigned(value)));

	// Tree navigation
	assign parent = (i_q - AW'(1)) >> 1;
	assign c1     = {i_q, 1'b1};
	assign c2     = c1 + XW'(1);
	assign cnt_x  = XW'(cnt_q);

	// Larger child; right child wins a tie
	assign take_c2  = (c2 < cnt_x) && !(m1_q > rd_data_q);
	assign best_val = take_c2 ? rd_data_q : m1_q;
	assign best_idx = take_c2 ? AW'(c2) : AW'(c1);

	assign up_move = (v_q > rd_data_q);
	assign dn_move = (best_val > v_q);

	// Memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = i_q;
		wr_data = v_q;
		case (state_q)
			S_IDLE: begin
				// fetch the last entry for a pop
				rd_en   = in_xfer && (action == ACT_POP) && !empty;
				rd_addr = AW'(cnt_q - CW'(1));
			end
			S_UP_CHK: begin
				if (i_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = parent;
				end
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (up_move) begin
					wr_data = rd_data_q;
				end
			end
			S_DN_CHK: begin
				if (c1 >= cnt_x) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(c1);
				end
			end
			S_DN_RD2: begin
				rd_en   = 1'b1;
				rd_addr = AW'(c2);
			end
			S_DN_CMP: begin
				wr_en = 1'b1;
				if (dn_move) begin
					wr_data = best_val;
				end
			end
			default: begin
			end
		endcase
	end

	// Heap store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Shadow copy of the root for the result
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == '0)) begin
			top_q <= wr_data;
		end
	end

	// Sequencer state, count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a result loaded in S_DONE keeps valid high
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (action == ACT_PUSH) begin
							if (full) begin
								state_q <= S_DONE;
							end else begin
								cnt_q   <= cnt_q + CW'(1);
								state_q <= S_UP_CHK;
							end
						end else begin
							if (empty) begin
								state_q <= S_DONE;
							end else begin
								cnt_q   <= cnt_q - CW'(1);
								state_q <= S_POP_CAP;
							end
						end
					end
				end
				S_UP_CHK: begin
					state_q <= (i_q == '0) ? S_DONE : S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= up_move ? S_UP_CHK : S_DONE;
				end
				S_POP_CAP: begin
					state_q <= empty ? S_DONE : S_DN_CHK;
				end
				S_DN_CHK: begin
					state_q <= (c1 >= cnt_x) ? S_DONE : S_DN_RD2;
				end
				S_DN_RD2: begin
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					state_q <= dn_move ? S_DN_CHK : S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the current item and the result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					v_q <= in_data;
					i_q <= AW'(cnt_q);
					if ((action == ACT_PUSH) && full) begin
						err_q <= ERR_FULL;
					end else if ((action == ACT_POP) && empty) begin
						err_q <= ERR_EMPTY;
					end else begin
						err_q <= ERR_OK;
					end
				end
			end
			S_UP_CMP: begin
				if (up_move) begin
					i_q <= parent;
				end
			end
			S_POP_CAP: begin
				v_q <= rd_data_q;
				i_q <= '0;
			end
			S_DN_RD2: begin
				m1_q <= rd_data_q;
			end
			S_DN_CMP: begin
				if (dn_move) begin
					i_q <= best_idx;
				end
			end
			S_DONE: begin
				if (out_free) begin
					top_out_q   <= empty ? '0 : VALUE_W'(top_q);
					cnt_out_q   <= COUNT_W'(cnt_q);
					empty_out_q <= empty;
					err_out_q   <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign top_value = top_out_q;
	assign count     = cnt_out_q;
	assign is_empty  = empty_out_q;
	assign error     = err_out_q;

endmodule

// ----- rtl/bmhq_checker.sv -----
// Port-level checker for the binary max-heap priority queue.
// Watches the top level's ports only; attached by the bind at the end.
// Depends on bmhq_pkg.
module bmhq_checker
	import bmhq_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [VALUE_W-1:0] top_value,
	input logic [COUNT_W-1:0]        count,
	input logic                      is_empty,
	input logic [ERR_W-1:0]          error
);

	// A stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(top_value) && $stable(count)
			&& $stable(error))
		else $error("result changed while stalled");

	// Empty flag agrees with the count
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (count == '0)))
		else $error("is_empty disagrees with count");

	// An empty queue reports zero as its top
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> (top_value == '0))
		else $error("nonzero top on empty queue");

	// A refused pop leaves the queue empty
	a_pop_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error == ERR_EMPTY) |-> is_empty)
		else $error("pop refused on a nonempty queue");

	// A refused push leaves the queue full
	a_push_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error == ERR_FULL) |-> (count == COUNT_W'(CAPACITY)))
		else $error("push refused on a queue that is not full");

endmodule

bind binary_max_heap_queue_top bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (.*);

// ----- verif/binary_max_heap_queue_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the binary max-heap priority queue top level.
// Holds a scoreboard class that mirrors the heap and checks every reply transfer.
// Depends on bmhq_pkg and binary_max_heap_queue_top.
module binary_max_heap_queue_top_test;
	import bmhq_pkg::*;

	localparam int HEAP_DEPTH = 1024;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

	// One reply of the queue, as expected or as seen
	typedef struct packed {
		logic signed [VALUE_W-1:0] top;
		logic [COUNT_W-1:0]        held;
		logic                      empty;
		err_t                      err;
	} heap_reply_t;

	// Mirror of the heap plus the replies still owed by the block
	class heap_scoreboard;
		logic signed [VALUE_W-1:0] slots [HEAP_DEPTH];
		int unsigned held;
		heap_reply_t owed_replies[$];
		int unsigned mismatches;
		int unsigned requests_seen;
		int unsigned replies_seen;
		int unsigned full_refusals;
		int unsigned empty_refusals;
		int unsigned peak_held;

		function void swap_slots(int unsigned a, int unsigned b);
			logic signed [VALUE_W-1:0] t;
			t = slots[a];
			slots[a] = slots[b];
			slots[b] = t;
		endfunction

		// Apply one accepted request to the mirror and queue its reply
		function void record_request(logic act, logic signed [VALUE_W-1:0] val);
			heap_reply_t r;
			int unsigned i, p, c1, c2, best;
			r.err = ERR_OK;
			requests_seen++;
			if (act == ACT_PUSH) begin
				if (held >= HEAP_DEPTH) begin
					r.err = ERR_FULL;
					full_refusals++;
				end else begin
					// sift up while strictly larger than the parent
					slots[held] = val;
					i = held;
					held++;
					while (i > 0) begin
						p = (i - 1) / 2;
						if (!(slots[i] > slots[p]))
							break;
						swap_slots(i, p);
						i = p;
					end
				end
			end else begin
				if (held == 0) begin
					r.err = ERR_EMPTY;
					empty_refusals++;
				end else begin
					// last entry to the root, then sift down; right child wins a tie
					held--;
					slots[0] = slots[held];
					i = 0;
					forever begin
						c1 = 2 * i + 1;
						c2 = c1 + 1;
						if (c1 >= held)
							break;
						best = c1;
						if (c2 < held && !(slots[c1] > slots[c2]))
							best = c2;
						if (!(slots[best] > slots[i]))
							break;
						swap_slots(i, best);
						i = best;
					end
				end
			end
			if (held > peak_held)
				peak_held = held;
			r.top   = (held > 0) ? slots[0] : '0;
			r.held  = held[COUNT_W-1:0];
			r.empty = (held == 0);
			owed_replies = {owed_replies, r};
		endfunction

		// Compare one reply transfer against the oldest owed reply
		function void check_reply(logic signed [VALUE_W-1:0] top, logic [COUNT_W-1:0] cnt,
				logic empty, err_t err);
			heap_reply_t e;
			replies_seen++;
			if (owed_replies.size() == 0) begin
				$display("%0t: unexpected reply top=%0d count=%0d empty=%0b error=%0d",
					$time, top, cnt, empty, err);
				mismatches++;
				return;
			end
			e = owed_replies.pop_front();
			if (top !== e.top) begin
				$display("%0t: top_value mismatch: expected %0d, got %0d", $time, e.top, top);
				mismatches++;
			end
			if (cnt !== e.held) begin
				$display("%0t: count mismatch: expected %0d, got %0d", $time, e.held, cnt);
				mismatches++;
			end
			if (empty !== e.empty) begin
				$display("%0t: is_empty mismatch: expected %0b, got %0b", $time, e.empty, empty);
				mismatches++;
			end
			if (err !== e.err) begin
				$display("%0t: error mismatch: expected %0d, got %0d", $time, e.err, err);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return owed_replies.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic action;
	logic signed [VALUE_W-1:0] value;
	logic out_valid;
	logic out_ready;
	logic signed [VALUE_W-1:0] top_value;
	logic [COUNT_W-1:0] count;
	logic is_empty;
	logic [ERR_W-1:0] error;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	heap_scoreboard sb = new;

	binary_max_heap_queue_top #(
		.CAPACITY  (HEAP_DEPTH),
		.DATA_WIDTH(VALUE_W)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.top_value(top_value),
		.count    (count),
		.is_empty (is_empty),
		.error    (error)
	);

	always #6 clk = ~clk;

	// Value mix: extremes, a narrow band for equal keys, full-range random
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(9);
		case (sel)
			0: begin
				case ($urandom_range(3))
					0: return VAL_MAX;
					1: return VAL_MIN;
					2: return '0;
					default: return -1;
				endcase
			end
			1, 2: return $signed(VALUE_W'($urandom_range(6))) - 3;
			default: return $signed($urandom());
		endcase
	endfunction

	// Request transfer; called at a falling edge, returns at a falling edge
	task automatic send_request(logic act, logic signed [VALUE_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		in_valid = 1'b1;
		action   = act;
		value    = val;
		do @(posedge clk); while (!in_ready);
		sb.record_request(act, val);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic run_mix(int unsigned items, int unsigned push_pct);
		logic act;
		repeat (items) begin
			act = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP;
			send_request(act, pick_value());
		end
	endtask

	// Receiver side: random back-pressure
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Reply monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_reply(top_value, count, is_empty, error);
	end

	// Watchdog
	initial begin
		#10ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		action   = ACT_PUSH;
		value    = '0;
		send_idle_pct = 32;
		recv_idle_pct = 53;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty pop, extremes, equal keys, drain, bit patterns
		send_request(ACT_POP, VAL_MAX);
		send_request(ACT_PUSH, '0);
		send_request(ACT_PUSH, VAL_MAX);
		send_request(ACT_PUSH, VAL_MIN);
		send_request(ACT_PUSH, -1);
		send_request(ACT_PUSH, 1);
		send_request(ACT_PUSH, 5);
		send_request(ACT_PUSH, 5);
		send_request(ACT_PUSH, 5);
		repeat (8) send_request(ACT_POP, VAL_MIN);
		send_request(ACT_POP, '0);
		send_request(ACT_PUSH, VAL_MIN);
		send_request(ACT_POP, -1);
		send_request(ACT_PUSH, 32'shaaaa_aaaa);
		send_request(ACT_PUSH, 32'sh5555_5555);
		send_request(ACT_POP, '0);
		send_request(ACT_POP, '0);

		// Small heaps, sender idles less than receiver
		run_mix(170, 60);

		// Roles swapped, pop-heavy so the queue drains and underflows
		send_idle_pct = 53;
		recv_idle_pct = 32;
		run_mix(170, 35);

		// No idling: fill to capacity, overflow, churn near full, deep pops
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (sb.held < HEAP_DEPTH)
			send_request(ACT_PUSH, pick_value());
		repeat (12) send_request(ACT_PUSH, pick_value());
		run_mix(40, 50);
		run_mix(120, 10);

		// Drain outstanding replies, then allow for stray ones
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("Run covered %0d transfers in and %0d replies, peak occupancy %0d of %0d,",
			sb.requests_seen, sb.replies_seen, sb.peak_held, HEAP_DEPTH);
		$display("with %0d pushes refused when full and %0d pops refused when empty.",
			sb.full_refusals, sb.empty_refusals);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- binary_max_heap_queue_top.f -----
rtl/bmhq_pkg.sv
rtl/binary_max_heap_queue_top.sv
rtl/bmhq_checker.sv
verif/binary_max_heap_queue_top_test.sv
